/* hdl/b64_pkg.sv */
// Base64 stream codec package: character codes, group job type, status structs
// and the alphabet lookup functions.
// No dependencies; the top level, front, job queue and back import it.
`default_nettype none

package b64_pkg;

	// Direction register codes
	typedef enum logic {
		DirEncode = 1'b0,
		DirDecode = 1'b1
	} dir_e_t;

	// Special characters
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChPad   = 8'h3D;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoZ   = 8'h7A;
	localparam logic [7:0] ChDig0  = 8'h30;
	localparam logic [7:0] ChDig9  = 8'h39;

	// Default depth of the job queue between front and back
	localparam int JobQDepth = 2;

	// One finished group, handed from the front to the back
	typedef struct packed {
		logic [23:0] bits;      // group, left aligned
		dir_e_t      dir;       // how to read the group
		logic [1:0]  last_idx;  // index of the final beat of this group
		logic [2:0]  nchars;    // encode: characters taken from the group
		logic        bad;       // decode: group held an invalid character
		logic        last;      // group ends the stream
	} job_t;

	// Front status toward the top level
	typedef struct packed {
		logic   group_empty;
		dir_e_t dir;
	} front_stat_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} jq_stat_t;

	// Sextet lookup result
	typedef struct packed {
		logic       ok;
		logic [5:0] sx;
	} sx_dec_t;

	// Map a sextet to its alphabet character
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return ChUpA + w;
		else if (v < 6'd52)
			return ChLoA + (w - 8'd26);
		else if (v < 6'd62)
			return ChDig0 + (w - 8'd52);
		else if (v == 6'd62)
			return ChPlus;
		else
			return ChSlash;
	endfunction

	// Map a character to its sextet; flag characters outside the alphabet
	function automatic sx_dec_t char_sextet(input logic [7:0] c);
		sx_dec_t r;
		logic [7:0] d;
		r.ok = 1'b1;
		d = 8'd0;
		if (c >= ChUpA && c <= ChUpZ)
			d = c - ChUpA;
		else if (c >= ChLoA && c <= ChLoZ)
			d = c - ChLoA + 8'd26;
		else if (c >= ChDig0 && c <= ChDig9)
			d = c - ChDig0 + 8'd52;
		else if (c == ChPlus)
			d = 8'd62;
		else if (c == ChSlash)
			d = 8'd63;
		else
			r.ok = 1'b0;
		r.sx = d[5:0];
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/b64_if.sv */
// Valid/ready stream interfaces of the Base64 codec: input beats and result beats.
// No dependencies.
`default_nettype none

interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       stream_end;
	logic       bad_char;

	modport source (output valid, output out_byte, output run_last, output stream_end,
		output bad_char, input ready);
	modport sink   (input valid, input out_byte, input run_last, input stream_end,
		input bad_char, output ready);
endinterface

`default_nettype wire

/* hdl/base64_stream_codec.sv */
// Channel   Dir   Beat payload                              Handshake
// in_ch     in    in_byte[7:0], in_last                     valid/ready
// out_ch    out   out_byte[7:0], run_last, stream_end,      valid/ready
//                 bad_char
// cfg       in    cfg_wdata (direction)                     cfg_wen, no wait
//
// Input beats enter every cycle while the job queue has room; the output register
// takes one result beat per cycle while the output is ready, so encode throughput is
// set by the output port and decode throughput by the input.
// An encode beat with in_last flushes its group as four result beats.
// Reset clears the direction (encode), the partial group, queue and output.
// Top level of the Base64 codec; uses b64_pkg, b64_if, b64_front, b64_job_q, b64_back.
`default_nettype none

module base64_stream_codec #(
	parameter int QUEUE_DEPTH = b64_pkg::JobQDepth
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	b64_in_if.sink     in_ch,
	b64_out_if.source  out_ch,
	input  wire logic  cfg_wen,
	input  wire logic  cfg_wdata
);
	import b64_pkg::*;

	logic        push;
	job_t        push_job;
	logic        pop;
	logic        head_valid;
	job_t        head_job;
	jq_stat_t    jq_stat;
	front_stat_t front_stat;

	b64_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.q_full   (jq_stat.full),
		.push     (push),
		.push_job (push_job),
		.stat     (front_stat)
	);

	b64_job_q #(
		.DEPTH(QUEUE_DEPTH)
	) u_job_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job),
		.stat      (jq_stat)
	);

	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_job  (head_job),
		.pop       (pop),
		.out_ch    (out_ch)
	);

	// Never push into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !jq_stat.full)
		else $error("job pushed into full queue");

	// Pop only a held job
	a_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !jq_stat.empty)
		else $error("job popped from empty queue");

	// A direction write leaves an empty group
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> front_stat.group_empty)
		else $error("group not cleared by direction write");

	// A closing encode beat always produces a job
	a_enc_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.in_last && front_stat.dir == DirEncode)
		|-> push)
		else $error("encode flush lost");

endmodule

`default_nettype wire

/* hdl/b64_front.sv */
// Front of the Base64 codec: accepts input beats, holds the direction register,
// collects groups and pushes each finished group as a job. Uses b64_pkg, b64_if.
`default_nettype none

module b64_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	b64_in_if.sink                  in_ch,
	input  wire logic               cfg_wen,
	input  wire logic               cfg_wdata,
	input  wire logic               q_full,
	output logic                    push,
	output b64_pkg::job_t           push_job,
	output b64_pkg::front_stat_t    stat
);
	import b64_pkg::*;

	dir_e_t      dir_q;
	logic [23:0] bits_q;
	logic [1:0]  fill_q;
	logic [1:0]  pad_q;
	logic        bad_q;

	logic        accept;
	logic [7:0]  c;
	sx_dec_t     dec;
	logic        is_pad;
	logic [1:0]  fill_e;
	logic [1:0]  fill_e1;
	logic [23:0] bits_e;
	logic        done_e;
	logic [1:0]  pad_new;
	logic [5:0]  sx;
	logic        bad_new;
	logic [23:0] bits_d;
	logic [2:0]  fill_d1;
	logic        done_d;
	logic [2:0]  pads;
	logic        done;

	assign c        = in_ch.in_byte;
	assign in_ch.ready = !q_full;
	assign accept   = in_ch.valid && in_ch.ready;
	assign dec      = char_sextet(c);
	assign is_pad   = (c == ChPad);

	// Encode: pack the byte into the next slot of the group
	always_comb begin
		fill_e = (fill_q > 2'd2) ? 2'd0 : fill_q;
		case (fill_e)
			2'd0:    bits_e = bits_q | {c, 16'h0000};
			2'd1:    bits_e = bits_q | {8'h00, c, 8'h00};
			default: bits_e = bits_q | {16'h0000, c};
		endcase
		fill_e1 = fill_e + 2'd1;
		done_e  = (fill_e1 == 2'd3) || in_ch.in_last;
	end

	// Decode: map the character, count pads, place the sextet
	always_comb begin
		pad_new = pad_q;
		if (is_pad && pad_q != 2'd3)
			pad_new = pad_q + 2'd1;
		sx      = is_pad ? 6'd0 : dec.sx;
		bad_new = bad_q || (!is_pad && !dec.ok);
		case (fill_q)
			2'd0:    bits_d = bits_q | {sx, 18'h00000};
			2'd1:    bits_d = bits_q | {6'h00, sx, 12'h000};
			2'd2:    bits_d = bits_q | {12'h000, sx, 6'h00};
			default: bits_d = bits_q | {18'h00000, sx};
		endcase
		fill_d1 = {1'b0, fill_q} + 3'd1;
		done_d  = (fill_d1 == 3'd4) || in_ch.in_last;
		pads    = {1'b0, pad_new} + (3'd4 - fill_d1);
	end

	// Build the job for a finished group
	always_comb begin
		push_job.last = in_ch.in_last;
		push_job.dir  = dir_q;
		if (dir_q == DirEncode) begin
			done              = done_e;
			push_job.bits     = bits_e;
			push_job.last_idx = 2'd3;
			push_job.nchars   = {1'b0, fill_e1} + 3'd1;
			push_job.bad      = 1'b0;
			push              = accept && done_e;
		end else begin
			done              = done_d;
			push_job.bits     = bits_d;
			push_job.last_idx = 2'd2 - pads[1:0];
			push_job.nchars   = 3'd4;
			push_job.bad      = bad_new;
			push              = accept && done_d && (pads < 3'd3);
		end
	end

	// Hold direction and group state; a direction write drops the partial group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DirEncode;
			bits_q <= '0;
			fill_q <= '0;
			pad_q  <= '0;
			bad_q  <= 1'b0;
		end else if (cfg_wen) begin
			dir_q  <= dir_e_t'(cfg_wdata);
			bits_q <= '0;
			fill_q <= '0;
			pad_q  <= '0;
			bad_q  <= 1'b0;
		end else if (accept) begin
			if (done) begin
				bits_q <= '0;
				fill_q <= '0;
				pad_q  <= '0;
				bad_q  <= 1'b0;
			end else if (dir_q == DirEncode) begin
				bits_q <= bits_e;
				fill_q <= fill_e1;
			end else begin
				bits_q <= bits_d;
				fill_q <= fill_d1[1:0];
				pad_q  <= pad_new;
				bad_q  <= bad_new;
			end
		end
	end

	assign stat.group_empty = (fill_q == 2'd0) && (bits_q == 24'h000000)
		&& (pad_q == 2'd0) && !bad_q;
	assign stat.dir = dir_q;

endmodule

`default_nettype wire

/* hdl/b64_job_q.sv */
// Short job queue between the front and the back of the Base64 codec.
// Register-based ring of DEPTH entries. Uses b64_pkg.
`default_nettype none

module b64_job_q #(
	parameter int DEPTH = b64_pkg::JobQDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire b64_pkg::job_t    push_job,
	input  wire logic             pop,
	output logic                  head_valid,
	output b64_pkg::job_t         head_job,
	output b64_pkg::jq_stat_t     stat
);
	import b64_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntMax = CntW'(DEPTH);

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	// Store a pushed job
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + PtrW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + PtrW'(1);
			if (push && !pop)
				count_q <= count_q + CntW'(1);
			else if (pop && !push)
				count_q <= count_q - CntW'(1);
		end
	end

	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CntMax);
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

/* hdl/b64_back.sv */
// Back of the Base64 codec: walks the head job into the output register one result beat
// per cycle, unless the output stalls. Uses b64_pkg, b64_if.
`default_nettype none

module b64_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire b64_pkg::job_t  head_job,
	output logic                pop,
	b64_out_if.source           out_ch
);
	import b64_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       stream_end_q;
	logic       bad_char_q;

	logic       emit;
	logic       final_beat;
	logic [5:0] sextet;
	logic [7:0] beat_byte;

	assign emit       = head_valid && (!out_valid_q || out_ch.ready);
	assign final_beat = (idx_q == head_job.last_idx);
	assign pop        = emit && final_beat;

	// Select the character or byte for the current beat
	always_comb begin
		case (idx_q)
			2'd0:    sextet = head_job.bits[23:18];
			2'd1:    sextet = head_job.bits[17:12];
			2'd2:    sextet = head_job.bits[11:6];
			default: sextet = head_job.bits[5:0];
		endcase
		if (head_job.dir == DirEncode) begin
			beat_byte = ({1'b0, idx_q} < head_job.nchars) ? sextet_char(sextet) : ChPad;
		end else begin
			case (idx_q)
				2'd0:    beat_byte = head_job.bits[23:16];
				2'd1:    beat_byte = head_job.bits[15:8];
				default: beat_byte = head_job.bits[7:0];
			endcase
		end
	end

	// Advance the beat index and hold the output register under stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				idx_q <= final_beat ? 2'd0 : idx_q + 2'd1;
			out_valid_q <= emit || (out_valid_q && !out_ch.ready);
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= beat_byte;
			run_last_q   <= final_beat;
			stream_end_q <= final_beat && head_job.last;
			bad_char_q   <= head_job.bad;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_byte   = out_byte_q;
	assign out_ch.run_last   = run_last_q;
	assign out_ch.stream_end = stream_end_q;
	assign out_ch.bad_char   = bad_char_q;

endmodule

`default_nettype wire

/* tb/sv/b64_codec_checker.sv */
`timescale 1ns / 100ps
// Checker for the Base64 stream codec: watches the input, result and direction ports,
// predicts every result beat and compares it field by field.
// Depends on b64_pkg and the stream interfaces in b64_if.

module b64_codec_checker (
	input  logic clk,
	input  logic arst_n,
	b64_in_if    in_ch,
	b64_out_if   out_ch,
	input  logic cfg_wen,
	input  logic cfg_wdata,
	output int   n_fail,
	output int   n_pending
);
	import b64_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       stream_end;
		logic       bad_char;
	} beat_t;

	localparam logic [511:0] Alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	beat_t       want_q[$];
	int          sextet_of[256];
	dir_e_t      mode;
	logic [23:0] acc_bits;
	int          acc_fill;
	int          acc_pads;
	logic        acc_bad;

	function automatic logic [7:0] letter(input int v);
		return Alphabet[8 * (63 - v) +: 8];
	endfunction

	function automatic void clear_acc();
		acc_bits = '0;
		acc_fill = 0;
		acc_pads = 0;
		acc_bad  = 1'b0;
	endfunction

	function automatic void expect_beat(input logic [7:0] data, input logic bad);
		beat_t b;
		b = '{data: data, run_last: 1'b0, stream_end: 1'b0, bad_char: bad};
		want_q.push_back(b);
	endfunction

	// Work out the result beats of one accepted input beat
	function automatic void predict(input logic [7:0] c, input logic fin);
		int first;
		int fill;
		int sx;
		int nout;
		first = want_q.size();
		fill  = acc_fill;
		if (mode == DirEncode) begin
			// pack bytes big-endian; a flushed tail keeps fill+1 characters, then pads
			acc_bits |= 24'(c) << (16 - 8 * fill);
			fill++;
			if (fill == 3 || fin) begin
				for (int i = 0; i < 4; i++)
					expect_beat((i <= fill) ? letter(int'(acc_bits[23 - 6 * i -: 6])) : ChPad,
						1'b0);
				clear_acc();
			end else begin
				acc_fill = fill;
			end
		end else begin
			// a pad counts as a zero sextet; anything outside the alphabet is zero and bad
			sx = 0;
			if (c == ChPad) begin
				if (acc_pads < 3)
					acc_pads++;
			end else if (sextet_of[c] < 0) begin
				acc_bad = 1'b1;
			end else begin
				sx = sextet_of[c];
			end
			acc_bits |= 24'(sx) << (18 - 6 * fill);
			fill++;
			if (fill == 4 || fin) begin
				// missing characters of a flushed group count as pads
				nout = 3 - acc_pads - (4 - fill);
				for (int i = 0; i < nout; i++)
					expect_beat(acc_bits[23 - 8 * i -: 8], acc_bad);
				clear_acc();
			end else begin
				acc_fill = fill;
			end
		end
		// tag the final beat of this item
		if (want_q.size() > first) begin
			want_q[want_q.size() - 1].run_last   = 1'b1;
			want_q[want_q.size() - 1].stream_end = fin;
		end
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
			n_fail++;
		end
	endfunction

	initial begin
		n_fail    = 0;
		n_pending = 0;
		mode      = DirEncode;
		clear_acc();
		for (int i = 0; i < 256; i++)
			sextet_of[i] = -1;
		for (int i = 0; i < 64; i++)
			sextet_of[letter(i)] = i;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_q.delete();
			mode = DirEncode;
			clear_acc();
			n_pending = 0;
		end else begin
			// retire one result beat against the oldest expectation
			if (out_ch.valid && out_ch.ready) begin
				if (want_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual 0x%02h",
						$time, out_ch.out_byte);
					n_fail++;
				end else begin
					beat_t w;
					w = want_q.pop_front();
					check_field("out_byte", w.data, out_ch.out_byte);
					check_field("run_last", w.run_last, out_ch.run_last);
					check_field("stream_end", w.stream_end, out_ch.stream_end);
					check_field("bad_char", w.bad_char, out_ch.bad_char);
				end
			end
			// predict an accepted input beat
			if (in_ch.valid && in_ch.ready)
				predict(in_ch.in_byte, in_ch.in_last);
			// a direction write also drops the partial group
			if (cfg_wen) begin
				mode = dir_e_t'(cfg_wdata);
				clear_acc();
			end
			n_pending = want_q.size();
		end
	end

endmodule

/* tb/sv/base64_stream_codec_test.sv */
`timescale 1ns / 100ps
// Top of the Base64 stream codec testbench: clock, reset, stimulus and verdict.
// Depends on b64_pkg, b64_if, the codec RTL and b64_codec_checker.

module base64_stream_codec_test;
	import b64_pkg::*;

	localparam int CycleLimit   = 200000;
	localparam int RandomItems  = 200;
	localparam int LongHold     = 300;
	localparam int SettleCycles = 12;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_wen;
	logic   cfg_wdata;
	int     n_fail;
	int     n_pending;
	int     items_sent;
	int     cycle_cnt;
	bit     in_burst;
	bit     out_burst;
	bit     hold_request;
	dir_e_t cur_dir;

	b64_in_if  in_ch();
	b64_out_if out_ch();

	base64_stream_codec uut (
		.clk,
		.arst_n,
		.in_ch,
		.out_ch,
		.cfg_wen,
		.cfg_wdata
	);

	b64_codec_checker u_check (
		.clk,
		.arst_n,
		.in_ch,
		.out_ch,
		.cfg_wen,
		.cfg_wdata,
		.n_fail,
		.n_pending
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, 18);
	endfunction

	// Offer one beat after a random gap and hold it until accepted
	task automatic push_item(input logic [7:0] b, input logic fin);
		int gap;
		gap = draw_wait(in_burst);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= fin;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic send_text(input string s, input bit fin);
		for (int i = 0; i < s.len(); i++)
			push_item(s[i], fin && i == s.len() - 1);
	endtask

	// Drop valid, wait for every expected beat, then let the pipeline go quiet
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (n_pending != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_direction(input dir_e_t d);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= d;
		cur_dir = d;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic encode_stream();
		int len;
		bit fin_ok;
		len    = $urandom_range(1, 10);
		fin_ok = $urandom_range(0, 7) != 0;
		for (int i = 0; i < len; i++)
			push_item(8'($urandom_range(0, 255)), fin_ok && i == len - 1);
	endtask

	function automatic logic [7:0] any_letter();
		return sextet_char(6'($urandom_range(0, 63)));
	endfunction

	// Mostly well-formed text with random letters; some corrupted, some pure noise
	task automatic decode_stream();
		logic [7:0] text[$];
		int groups;
		int tail;
		int kind;
		bit fin;
		kind = $urandom_range(0, 7);
		fin  = 1'b1;
		if (kind == 0) begin
			repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
			fin = $urandom_range(0, 1);
		end else begin
			groups = $urandom_range(0, 3);
			tail   = $urandom_range(0, 4);
			if (groups == 0 && tail == 0)
				groups = 1;
			repeat (groups * 4) text.push_back(any_letter());
			case (tail)
				1: begin
					repeat (2) text.push_back(any_letter());
					repeat (2) text.push_back(ChPad);
				end
				2: begin
					repeat (3) text.push_back(any_letter());
					text.push_back(ChPad);
				end
				3: repeat (2) text.push_back(any_letter());
				4: repeat (3) text.push_back(any_letter());
				default: ;
			endcase
			if (kind == 1) begin
				foreach (text[i])
					if ($urandom_range(0, 4) == 0)
						text[i] = $urandom_range(0, 1) ? ChPad : 8'($urandom_range(0, 255));
				if ($urandom_range(0, 2) == 0)
					fin = 1'b0;
			end
		end
		foreach (text[i])
			push_item(text[i], fin && i == text.size() - 1);
	endtask

	// Result side: random hold-offs per beat, one long hold on request
	initial begin
		int wait_n;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				wait_n = LongHold;
				hold_request = 1'b0;
			end else begin
				wait_n = draw_wait(out_burst);
			end
			@(negedge clk);
			if (wait_n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Abort a hung run
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** base64_stream_codec: FAILED **");
		$finish;
	end

	initial begin
		int phase;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.in_last = 1'b0;
		cfg_wen       = 1'b0;
		cfg_wdata     = 1'b0;
		items_sent    = 0;
		in_burst      = 1'b0;
		out_burst     = 1'b0;
		hold_request  = 1'b0;
		cur_dir       = DirEncode;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// encode: full group of extremes, one-byte and two-byte tails
		write_direction(DirEncode);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'hFB, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'hFE, 1'b1);
		// leave a partial group for the direction write to drop
		push_item(8'h5A, 1'b0);
		settle();

		// decode: plain group, padding, misplaced pad, too many pads, silent end, bad chars
		write_direction(DirDecode);
		send_text("+/z0", 1'b0);
		send_text("Zg==", 1'b1);
		send_text("8=a", 1'b1);
		send_text("A===", 1'b0);
		send_text("T", 1'b1);
		push_item(8'h20, 1'b0);
		push_item(8'h00, 1'b0);
		push_item("a", 1'b0);
		push_item(8'h7B, 1'b1);

		// random phases, each under a fresh direction
		items_sent = 0;
		phase = 0;
		while (items_sent < RandomItems) begin
			settle();
			write_direction(dir_e_t'($urandom_range(0, 1)));
			in_burst  = $urandom_range(0, 2) == 0;
			out_burst = $urandom_range(0, 2) == 0;
			if (phase == 1) begin
				// keep offering beats while the result side stalls
				in_burst = 1'b1;
				hold_request = 1'b1;
			end
			repeat ($urandom_range(2, 5)) begin
				if (cur_dir == DirDecode)
					decode_stream();
				else
					encode_stream();
			end
			phase++;
		end

		settle();
		if (n_fail == 0 && n_pending == 0)
			$display("** base64_stream_codec: PASSED **");
		else
			$display("** base64_stream_codec: FAILED **");
		$finish;
	end

endmodule
